FILE: src/mcw_pkg.sv
// Shared types and constants for the multilinear corner weight generator.
package mcw_pkg;

  localparam int unsigned NumAxes    = 6;
  localparam int unsigned NumPoints  = 64;
  localparam int unsigned ValueBits  = 48;
  localparam int unsigned FracBits   = 24;
  localparam int unsigned WeightBits = FracBits + 1;
  localparam int unsigned IdxBits    = 6;
  localparam int unsigned AxisBits   = 3;
  localparam int unsigned AddrBits   = AxisBits + IdxBits;
  localparam int unsigned DiffBits   = ValueBits + 1;
  localparam int unsigned LenBits    = 7;

  localparam logic [WeightBits-1:0] OneFx = WeightBits'(1) << FracBits;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [2:0] CfgAxisCount = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_START,
    ST_SCAN,
    ST_CMP,
    ST_FRAC,
    ST_DIV,
    ST_STORE,
    ST_AX_NEXT,
    ST_W_INIT,
    ST_W_MUL,
    ST_W_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DiffBits-1:0] num;
    logic [DiffBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [FracBits-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/mcw_div.sv
// Restoring fraction divider producing one quotient bit per cycle.
module mcw_div (
  input  logic              clk,
  input  logic              rst,
  input  mcw_pkg::div_req_t req,
  output mcw_pkg::div_rsp_t rsp
);

  logic [mcw_pkg::DiffBits:0]   rem;
  logic [mcw_pkg::DiffBits-1:0] den;
  logic [mcw_pkg::FracBits-1:0] quot;
  logic [4:0]                   count;
  logic                         busy;
  logic                         done;
  logic [mcw_pkg::DiffBits:0]   shifted;
  logic                         fits;

  always_comb begin
    shifted = {rem[mcw_pkg::DiffBits-1:0], 1'b0};
    fits    = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'(mcw_pkg::FracBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num};
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? shifted - {1'b0, den} : shifted;
      quot <= {quot[mcw_pkg::FracBits-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> count < 5'(mcw_pkg::FracBits))
    else $error("divider step count out of range");

endmodule

FILE: src/multilinear_corner_weights.sv
// Top level of the multilinear interpolation corner and weight generator.
//
// Slave stream: s_tuser is the opcode. A load item writes one grid point into
// the grid memory and gives no result. A query item carries six axis values
// and gives 2^n result items, n being the number of axes in use whose length
// exceeds one. Results leave on the master stream, m_tlast on the final one.
// The block takes one item at a time. A query runs, per axis in use whose
// length exceeds one, a linear scan of the grid memory, a read state and a
// compare state per point (one memory port, registered read data), then,
// unless the fraction is zero or one, a bit-serial division. Each corner
// then runs one setup step, six multiplier steps over the axes and one
// output step. The output register holds a result while the receiver
// stalls; the next corner is computed meanwhile and waits for it.
// Configuration writes on cfg_we take effect at once. Reset sets six
// axes of length one and clears the control state; the grid memory holds
// garbage until written.
module multilinear_corner_weights (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // axis_sel, point_index, point_value, query0..query5, zero pad
  input  logic [351:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner_idx0..corner_idx5, corner_weight, clamped, zero pad
  output logic [63:0]  m_tdata,
  output logic         m_tlast
);

  localparam int unsigned VB = mcw_pkg::ValueBits;
  localparam int unsigned WB = mcw_pkg::WeightBits;
  localparam int unsigned IB = mcw_pkg::IdxBits;

  mcw_pkg::state_t state, state_next;

  logic [2:0]                  axis_count;
  logic [mcw_pkg::LenBits-1:0] len_axis [mcw_pkg::NumAxes];

  logic signed [VB-1:0] grid_mem [mcw_pkg::NumAxes * mcw_pkg::NumPoints];
  logic signed [VB-1:0] rdata;
  logic [mcw_pkg::AddrBits-1:0] rd_addr;
  logic rd_en;

  logic signed [VB-1:0] qv [mcw_pkg::NumAxes];
  logic signed [VB-1:0] prev, glo, ghi;
  logic [2:0]  ax;
  logic [IB-1:0] idx, hi_sel;
  logic [WB-1:0] frac;

  logic [IB-1:0] lo_index [mcw_pkg::NumAxes];
  logic [IB-1:0] hi_index [mcw_pkg::NumAxes];
  logic [WB-1:0] hi_fraction [mcw_pkg::NumAxes];
  logic [2:0]    bitpos [mcw_pkg::NumAxes];
  logic [mcw_pkg::NumAxes-1:0] doubled;
  logic [2:0]    nd;
  logic          clamp_flag;

  logic [IB-1:0] corner_counter;
  logic [2:0]    wa;
  logic [WB-1:0] weight;

  logic          in_acc, out_load;
  logic [2:0]    n_ax;
  logic [mcw_pkg::LenBits-1:0] len_eff;
  logic          skip_axis, hit, at_end, f_zero, f_one, last_k;
  logic [IB-1:0] k_mask;
  logic          take_hi;
  logic [WB-1:0] fac;
  logic [2*WB-1:0] prod;
  logic [IB-1:0] cidx [mcw_pkg::NumAxes];

  mcw_pkg::div_req_t div_req;
  mcw_pkg::div_rsp_t div_rsp;

  mcw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_acc = s_tvalid && s_tready;

  always_comb begin
    if (axis_count == 3'd0) begin
      n_ax = 3'd1;
    end else if (axis_count > 3'(mcw_pkg::NumAxes)) begin
      n_ax = 3'(mcw_pkg::NumAxes);
    end else begin
      n_ax = axis_count;
    end
    if (len_axis[ax] == '0) begin
      len_eff = 7'd1;
    end else if (len_axis[ax] > 7'(mcw_pkg::NumPoints)) begin
      len_eff = 7'(mcw_pkg::NumPoints);
    end else begin
      len_eff = len_axis[ax];
    end
    skip_axis = (ax >= n_ax) || (len_eff == 7'd1);
    hit       = rdata >= qv[ax];
    at_end    = idx == IB'(len_eff - 7'd1);
    f_zero    = (ghi <= glo) || (qv[ax] <= glo);
    f_one     = qv[ax] >= ghi;
    k_mask    = IB'((7'd1 << nd) - 7'd1);
    last_k    = corner_counter == k_mask;
    take_hi   = corner_counter[bitpos[wa]];
    fac       = take_hi ? hi_fraction[wa] : mcw_pkg::OneFx - hi_fraction[wa];
    prod      = weight * fac;
    for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
      if (doubled[a]) begin
        cidx[a] = corner_counter[bitpos[a]] ? hi_index[a] : lo_index[a];
      end else begin
        cidx[a] = '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mcw_pkg::ST_IDLE: begin
        if (in_acc && s_tuser == mcw_pkg::OpQuery) begin
          state_next = mcw_pkg::ST_AX_START;
        end
      end
      mcw_pkg::ST_AX_START: state_next = skip_axis ? mcw_pkg::ST_AX_NEXT : mcw_pkg::ST_SCAN;
      mcw_pkg::ST_SCAN:     state_next = mcw_pkg::ST_CMP;
      mcw_pkg::ST_CMP:      state_next = (hit || at_end) ? mcw_pkg::ST_FRAC : mcw_pkg::ST_SCAN;
      mcw_pkg::ST_FRAC: begin
        state_next = (f_zero || f_one) ? mcw_pkg::ST_STORE : mcw_pkg::ST_DIV;
      end
      mcw_pkg::ST_DIV:      state_next = div_rsp.done ? mcw_pkg::ST_STORE : mcw_pkg::ST_DIV;
      mcw_pkg::ST_STORE:    state_next = mcw_pkg::ST_AX_NEXT;
      mcw_pkg::ST_AX_NEXT: begin
        state_next = (ax == 3'(mcw_pkg::NumAxes - 1)) ? mcw_pkg::ST_W_INIT
                                                       : mcw_pkg::ST_AX_START;
      end
      mcw_pkg::ST_W_INIT:   state_next = mcw_pkg::ST_W_MUL;
      mcw_pkg::ST_W_MUL: begin
        state_next = (wa == 3'(mcw_pkg::NumAxes - 1)) ? mcw_pkg::ST_W_OUT : mcw_pkg::ST_W_MUL;
      end
      mcw_pkg::ST_W_OUT: begin
        if (out_load) begin
          state_next = last_k ? mcw_pkg::ST_IDLE : mcw_pkg::ST_W_INIT;
        end
      end
      default: state_next = mcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = state == mcw_pkg::ST_IDLE;
    rd_en         = state == mcw_pkg::ST_SCAN;
    rd_addr       = {ax, idx};
    out_load      = (state == mcw_pkg::ST_W_OUT) && (!m_tvalid || m_tready);
    div_req.start = (state == mcw_pkg::ST_FRAC) && !f_zero && !f_one;
    div_req.num   = {qv[ax][VB-1], qv[ax]} - {glo[VB-1], glo};
    div_req.den   = {ghi[VB-1], ghi} - {glo[VB-1], glo};
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == mcw_pkg::OpLoad && s_tdata[2:0] < 3'(mcw_pkg::NumAxes)) begin
      grid_mem[{s_tdata[2:0], s_tdata[8:3]}] <= s_tdata[56:9];
    end
    if (rd_en) begin
      rdata <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mcw_pkg::ST_IDLE;
      axis_count <= 3'(mcw_pkg::NumAxes);
      for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
        len_axis[a]    <= 7'd1;
        lo_index[a]    <= '0;
        hi_index[a]    <= '0;
        hi_fraction[a] <= '0;
        bitpos[a]      <= '0;
      end
      doubled        <= '0;
      nd             <= '0;
      clamp_flag     <= 1'b0;
      corner_counter <= '0;
      ax             <= '0;
      wa             <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == mcw_pkg::CfgAxisCount) begin
          axis_count <= cfg_data[2:0];
        end else if (cfg_index <= 3'(mcw_pkg::NumAxes)) begin
          len_axis[cfg_index - 3'd1] <= cfg_data;
        end
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        mcw_pkg::ST_IDLE: begin
          if (in_acc && s_tuser == mcw_pkg::OpQuery) begin
            for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
              lo_index[a]    <= '0;
              hi_index[a]    <= '0;
              hi_fraction[a] <= '0;
              bitpos[a]      <= '0;
            end
            doubled        <= '0;
            nd             <= '0;
            clamp_flag     <= 1'b0;
            corner_counter <= '0;
            ax             <= '0;
          end
        end
        mcw_pkg::ST_CMP: begin
          if (hit || at_end) begin
            if (!hit) begin
              clamp_flag <= 1'b1;
            end
          end
        end
        mcw_pkg::ST_STORE: begin
          lo_index[ax]    <= (hi_sel == '0) ? '0 : hi_sel - IB'(1);
          hi_index[ax]    <= hi_sel;
          hi_fraction[ax] <= frac;
          bitpos[ax]      <= nd;
          doubled[ax]     <= 1'b1;
          nd              <= nd + 3'd1;
        end
        mcw_pkg::ST_AX_NEXT: begin
          ax <= ax + 3'd1;
        end
        mcw_pkg::ST_W_INIT: begin
          wa <= '0;
        end
        mcw_pkg::ST_W_MUL: begin
          wa <= wa + 3'd1;
        end
        mcw_pkg::ST_W_OUT: begin
          if (out_load) begin
            m_tvalid       <= 1'b1;
            corner_counter <= corner_counter + IB'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == mcw_pkg::OpQuery) begin
      for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
        qv[a] <= s_tdata[57 + a*VB +: VB];
      end
    end
    if (state == mcw_pkg::ST_AX_START) begin
      idx <= '0;
    end
    if (state == mcw_pkg::ST_CMP) begin
      if (hit || at_end) begin
        hi_sel <= idx;
        glo    <= (idx == '0) ? rdata : prev;
        ghi    <= rdata;
      end else begin
        prev <= rdata;
        idx  <= idx + IB'(1);
      end
    end
    if (state == mcw_pkg::ST_FRAC) begin
      frac <= f_zero ? '0 : mcw_pkg::OneFx;
    end
    if (state == mcw_pkg::ST_DIV && div_rsp.done) begin
      frac <= {1'b0, div_rsp.quot};
    end
    if (state == mcw_pkg::ST_W_INIT) begin
      weight <= mcw_pkg::OneFx;
    end
    if (state == mcw_pkg::ST_W_MUL && doubled[wa] && fac != mcw_pkg::OneFx) begin
      weight <= prod[mcw_pkg::FracBits +: WB];
    end
    if (out_load) begin
      m_tdata <= {2'b00, clamp_flag, weight, cidx[5], cidx[4], cidx[3], cidx[2],
                  cidx[1], cidx[0]};
      m_tlast <= last_k;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_load |=> m_tvalid)
    else $error("corner loaded but output not valid");
  assert property (@(posedge clk) disable iff (rst)
    (state == mcw_pkg::ST_W_MUL) |-> ($countones(doubled) == int'(nd)))
    else $error("doubled axis count mismatch");
  assert property (@(posedge clk) disable iff (rst)
    (state == mcw_pkg::ST_W_OUT) |-> (corner_counter <= k_mask))
    else $error("corner counter beyond corner count");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && m_tready) |->
      (state == mcw_pkg::ST_IDLE || state == mcw_pkg::ST_AX_START ||
       !(state == mcw_pkg::ST_W_OUT && corner_counter != '0)))
    else $error("final corner sent while corners remain");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the multilinear corner weight generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned TargetItems = 400;
  localparam longint MinValue = -(64'sd1 <<< 47);
  localparam longint MaxValue = (64'sd1 <<< 47) - 1;
  localparam longint Q1 = 65536;
  localparam logic [2:0] CfgLenAxis0 = 3'd1;

  typedef struct packed {
    logic              op;
    logic [2:0]        axis;
    logic [5:0]        pt;
    logic signed [47:0] val;
    logic [5:0][47:0]  q;
  } grid_item_t;

  typedef struct packed {
    logic             last;
    logic             clamped;
    logic [24:0]      weight;
    logic [5:0][5:0]  idx;
  } corner_t;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] reg_idx;
    logic [6:0] reg_val;
    grid_item_t it;
    logic       pinned;
  } row_t;

  localparam corner_t PinnedCorner = '{last: 1'b1, clamped: 1'b0, weight: mcw_pkg::OneFx,
                                       idx: '0};

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [6:0] cfg_data;
  logic s_tvalid, s_tready, s_tuser;
  logic [351:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [63:0] m_tdata;

  multilinear_corner_weights dut (.*);

  longint grid [mcw_pkg::NumAxes][mcw_pkg::NumPoints];
  logic [2:0] axis_count_reg;
  logic [6:0] len_reg [mcw_pkg::NumAxes];
  corner_t corners_due [$];
  row_t directed_rows [$];
  int unsigned cycles, n_items, n_corners, n_errors, n_mismatch;
  bit send_calm, recv_calm, held_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int eff_len(int a);
    int n;
    n = int'(len_reg[a]);
    if (n == 0) n = 1;
    if (n > int'(mcw_pkg::NumPoints)) n = int'(mcw_pkg::NumPoints);
    return n;
  endfunction

  function automatic int eff_axes();
    int n;
    n = int'(axis_count_reg);
    if (n == 0) n = 1;
    if (n > int'(mcw_pkg::NumAxes)) n = int'(mcw_pkg::NumAxes);
    return n;
  endfunction

  // Updates the grid copy for a load, or queues the corners of a query.
  function automatic void predict_corners(grid_item_t it);
    bit dbl [mcw_pkg::NumAxes];
    int lo_i [mcw_pkg::NumAxes], hi_i [mcw_pkg::NumAxes];
    longint unsigned frac [mcw_pkg::NumAxes];
    int n, nd, len, hi, bit_pos;
    longint qv, diff, span;
    logic [79:0] quot;
    bit clamp;
    longint unsigned w, fac;
    corner_t c;
    if (it.op == mcw_pkg::OpLoad) begin
      if (it.axis < mcw_pkg::NumAxes) grid[it.axis][it.pt] = longint'(it.val);
      return;
    end
    n = eff_axes();
    nd = 0;
    clamp = 0;
    for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
      dbl[a] = 0; lo_i[a] = 0; hi_i[a] = 0; frac[a] = 0;
      len = eff_len(a);
      if (a >= n || len == 1) continue;
      qv = longint'($signed(it.q[a]));
      hi = 0;
      while (hi < len && grid[a][hi] < qv) hi++;
      if (hi == len) begin
        hi = len - 1;
        clamp = 1;
      end
      lo_i[a] = (hi == 0) ? 0 : hi - 1;
      hi_i[a] = hi;
      if (grid[a][hi] <= grid[a][lo_i[a]] || qv <= grid[a][lo_i[a]]) frac[a] = 0;
      else if (qv >= grid[a][hi]) frac[a] = 64'(mcw_pkg::OneFx);
      else begin
        diff = qv - grid[a][lo_i[a]];
        span = grid[a][hi] - grid[a][lo_i[a]];
        quot = (80'(diff) << mcw_pkg::FracBits) / 80'(span);
        frac[a] = 64'(quot[24:0]);
      end
      dbl[a] = 1;
      nd++;
    end
    for (int k = 0; k < (1 << nd); k++) begin
      w = 64'(mcw_pkg::OneFx);
      bit_pos = 0;
      c = '0;
      for (int a = 0; a < mcw_pkg::NumAxes; a++) begin
        if (!dbl[a]) continue;
        if ((k >> bit_pos) & 1) begin
          c.idx[a] = 6'(hi_i[a]);
          fac = frac[a];
        end else begin
          c.idx[a] = 6'(lo_i[a]);
          fac = 64'(mcw_pkg::OneFx) - frac[a];
        end
        bit_pos++;
        if (fac != 64'(mcw_pkg::OneFx)) w = (w * fac) >> mcw_pkg::FracBits;
      end
      c.weight = w[24:0];
      c.clamped = clamp;
      c.last = (k + 1 == (1 << nd));
      corners_due.insert(corners_due.size(), c);
    end
  endfunction

  task automatic send_item(grid_item_t it, bit pinned);
    int gap;
    gap = send_calm ? 0 : int'($urandom_range(0, 4));
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {7'b0, it.q, it.val, it.pt, it.axis};
    do @(posedge clk); while (!s_tready);
    n_items++;
    if (n_items % 32 == 0) send_calm = ($urandom_range(0, 3) == 0);
    if (pinned) corners_due.insert(corners_due.size(), PinnedCorner);
    else predict_corners(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (corners_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == mcw_pkg::CfgAxisCount) axis_count_reg = val[2:0];
    else len_reg[idx - 3'd1] = val;
  endtask

  function automatic grid_item_t load_item(int a, int p, longint v);
    grid_item_t it;
    it = '0;
    it.op = mcw_pkg::OpLoad;
    it.axis = 3'(a);
    it.pt = 6'(p);
    it.val = v[47:0];
    return it;
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [6:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_item(grid_item_t it, bit pinned);
    row_t r;
    r = '0;
    r.it = it;
    r.pinned = pinned;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic grid_item_t query_on_axis0(longint v);
    grid_item_t it;
    it = '0;
    it.op = mcw_pkg::OpQuery;
    it.q[0] = v[47:0];
    return it;
  endfunction

  function automatic longint rand_value();
    longint v;
    if ($urandom_range(0, 1)) v = longint'($signed({$urandom, $urandom}) >>> 16);
    else v = longint'($urandom_range(0, 2000)) * Q1 - 1000 * Q1;
    return v;
  endfunction

  function automatic longint rand_query(int a);
    int len, i;
    longint lo, hi;
    longint unsigned r;
    len = eff_len(a);
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return rand_value();
      1: return grid[a][$urandom_range(0, len - 1)];
      2: return ($urandom_range(0, 1)) ? MinValue : grid[a][0] - longint'(r % 1000);
      3: begin
        hi = grid[a][len - 1];
        if (hi >= MaxValue) return MaxValue;
        return hi + 1 + longint'(r % 64'(MaxValue - hi));
      end
      default: begin
        i = int'($urandom_range(0, len - 2));
        lo = grid[a][i];
        hi = grid[a][i + 1];
        if (hi <= lo) return lo;
        return lo + longint'(r % 64'(hi - lo));
      end
    endcase
  endfunction

  task automatic run_phase(int phase);
    longint vals [$];
    grid_item_t it;
    int len, nq, a;
    wait_idle();
    if (phase == 0) write_reg(mcw_pkg::CfgAxisCount, 7'd0);
    else if (phase == 1) write_reg(mcw_pkg::CfgAxisCount, 7'd7);
    else if (phase == 3) write_reg(mcw_pkg::CfgAxisCount, 7'd6);
    else write_reg(mcw_pkg::CfgAxisCount, 7'($urandom_range(1, 6)));
    for (int i = 0; i < mcw_pkg::NumAxes; i++) begin
      case ($urandom_range(0, 19))
        0: len = 0;
        1: len = 8;
        default: len = int'($urandom_range(1, 4));
      endcase
      if (phase == 2 && i == 0) len = 127;
      if (phase == 3 && i == 5) len = 64;
      write_reg(CfgLenAxis0 + 3'(i), 7'(len));
    end
    for (int i = 0; i < eff_axes(); i++) begin
      len = eff_len(i);
      if (len == 1) continue;
      vals.delete();
      for (int p = 0; p < len; p++) vals.insert(vals.size(), rand_value());
      if ($urandom_range(0, 7) != 0) vals.sort();
      if ($urandom_range(0, 5) == 0) vals[$urandom_range(1, len - 1)] = vals[0];
      for (int p = 0; p < len; p++) send_item(load_item(i, p, vals[p]), 1'b0);
    end
    nq = int'($urandom_range(4, 12));
    for (int j = 0; j < nq; j++) begin
      case ($urandom_range(0, 19))
        0: send_item(load_item(int'($urandom_range(6, 7)), int'($urandom_range(0, 63)),
                               rand_value()), 1'b0);
        1: begin
          a = int'($urandom_range(0, mcw_pkg::NumAxes - 1));
          send_item(load_item(a, int'($urandom_range(0, eff_len(a) - 1)), rand_value()),
                    1'b0);
        end
        default: ;
      endcase
      it = '0;
      it.op = mcw_pkg::OpQuery;
      it.axis = 3'($urandom);
      it.pt = 6'($urandom);
      it.val = 48'({$urandom, $urandom});
      for (int i = 0; i < mcw_pkg::NumAxes; i++) begin
        if (i < eff_axes() && eff_len(i) > 1) it.q[i] = 48'(rand_query(i));
        else it.q[i] = 48'({$urandom, $urandom});
      end
      send_item(it, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      corner_t got, want;
      got = '{last: m_tlast, clamped: m_tdata[61], weight: m_tdata[60:36], idx: m_tdata[35:0]};
      n_corners++;
      if (corners_due.size() == 0) begin
        n_errors++;
        if (n_mismatch++ < 10) $display("tb: unexpected corner %h", got);
      end else begin
        want = corners_due.pop_front();
        if (got.idx !== want.idx || got.weight !== want.weight ||
            got.clamped !== want.clamped || got.last !== want.last) begin
          n_errors++;
          if (n_mismatch++ < 10)
            $display("tb: corner mismatch idx %h/%h weight %h/%h clamp %b/%b last %b/%b",
                     want.idx, got.idx, want.weight, got.weight,
                     want.clamped, got.clamped, want.last, got.last);
        end
      end
    end
  end

  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = recv_calm ? 0 : int'($urandom_range(0, 4));
      if (!held_off && n_corners >= 100) begin
        held_off = 1;
        gap = 3000;
      end
      repeat (gap) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (n_corners % 48 == 0) recv_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    axis_count_reg = 3'd6;
    foreach (len_reg[i]) len_reg[i] = 7'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_item(query_on_axis0(0), 1'b1);
    add_cfg(mcw_pkg::CfgAxisCount, 7'd1);
    add_cfg(CfgLenAxis0, 7'd4);
    add_item(load_item(0, 0, MinValue), 1'b0);
    add_item(load_item(0, 1, -10 * Q1), 1'b0);
    add_item(load_item(0, 2, 5 * Q1), 1'b0);
    add_item(load_item(0, 3, MaxValue), 1'b0);
    add_item(load_item(7, 0, 0), 1'b0);
    add_item(load_item(6, 63, -1), 1'b0);
    add_item(query_on_axis0(MinValue), 1'b0);
    add_item(query_on_axis0(MaxValue), 1'b0);
    add_item(query_on_axis0(0), 1'b0);
    add_item(query_on_axis0(5 * Q1), 1'b0);
    add_item(load_item(0, 3, 100 * Q1), 1'b0);
    add_item(query_on_axis0(MaxValue), 1'b0);
    add_item(load_item(0, 3, 5 * Q1), 1'b0);
    add_item(query_on_axis0(MaxValue), 1'b0);
    add_item(load_item(0, 3, Q1), 1'b0);
    add_item(query_on_axis0(50 * Q1), 1'b0);
    add_cfg(mcw_pkg::CfgAxisCount, 7'd0);
    add_cfg(CfgLenAxis0, 7'd0);
    add_item(query_on_axis0(MaxValue), 1'b1);
    add_cfg(mcw_pkg::CfgAxisCount, 7'd7);
    add_item(query_on_axis0(MinValue), 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].it, directed_rows[i].pinned);
      end
    end

    phase = 0;
    while (n_items < TargetItems) run_phase(phase++);
    wait_idle();

    if (n_errors == 0 && corners_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
